@@ rtl/tsfm_pkg.sv @@
// Shared types and constants for the temperature sensor FIR monitor.
`default_nettype none

package tsfm_pkg;

    localparam int RAW_W      = 12;
    localparam int TEMP_W     = 19;
    localparam int COEFF_W    = 16;
    localparam int THR_W      = 11;
    localparam int PERIOD_W   = 16;
    localparam int OUT_W      = 21;
    localparam int NUM_COEFF  = 5;
    localparam int COEFF_IDX_W = $clog2(NUM_COEFF);
    localparam int HIST_D     = 4;
    localparam int HIST_IDX_W = $clog2(HIST_D);
    localparam int CFG_IDX_W  = 3;

    localparam int DIGIT_W    = 4;
    localparam int DIGITS     = COEFF_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);
    localparam int PROD_W     = TEMP_W + DIGIT_W + 1;
    localparam int ACC_W      = TEMP_W + COEFF_W + 3;
    localparam int FRAC_W     = 12;
    localparam int THR_SHIFT  = 8;

    localparam int TEMP_GAIN   = 75;
    localparam int TEMP_OFFSET = 71424;
    localparam int OUT_MAX     = 1048575;
    localparam int OUT_MIN     = -1048576;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF4    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd6;

    localparam logic [COEFF_W-1:0] COEFF0_RST = 16'd2458;
    localparam logic [COEFF_W-1:0] COEFF1_RST = 16'd2048;
    localparam logic [COEFF_W-1:0] COEFF2_RST = 16'd41;
    localparam logic [COEFF_W-1:0] COEFF3_RST = 16'd1229;
    localparam logic [COEFF_W-1:0] COEFF4_RST = 16'd2048;
    localparam logic [THR_W-1:0]   THR_RST    = 11'd30;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;

    typedef struct packed {
        logic [NUM_COEFF-1:0][COEFF_W-1:0] coeff;
        logic [THR_W-1:0]                  threshold;
        logic [PERIOD_W-1:0]               period;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic step;
    } mac_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ rtl/tsfm_cfg.sv @@
// Configuration register file: FIR coefficients, alarm threshold, display period.
`default_nettype none

module tsfm_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tsfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tsfm_pkg::COEFF_W-1:0]     cfg_data,
    output tsfm_pkg::cfg_t                        cfg
);
    import tsfm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_COEFF0:    cfg_next.coeff[0]  = cfg_data;
                REG_COEFF1:    cfg_next.coeff[1]  = cfg_data;
                REG_COEFF2:    cfg_next.coeff[2]  = cfg_data;
                REG_COEFF3:    cfg_next.coeff[3]  = cfg_data;
                REG_COEFF4:    cfg_next.coeff[4]  = cfg_data;
                REG_THRESHOLD: cfg_next.threshold = cfg_data[THR_W-1:0];
                REG_PERIOD:    cfg_next.period    = cfg_data[PERIOD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coeff[0]  <= COEFF0_RST;
            cfg_reg.coeff[1]  <= COEFF1_RST;
            cfg_reg.coeff[2]  <= COEFF2_RST;
            cfg_reg.coeff[3]  <= COEFF3_RST;
            cfg_reg.coeff[4]  <= COEFF4_RST;
            cfg_reg.threshold <= THR_RST;
            cfg_reg.period    <= PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsfm_mac.sv @@
// Digit-serial multiply-accumulate over the FIR window, with floor shift and saturation.
`default_nettype none

module tsfm_mac (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tsfm_pkg::mac_ctrl_t                 ctrl,
    input  wire logic signed [tsfm_pkg::TEMP_W-1:0]  sample,
    input  wire logic [tsfm_pkg::COEFF_W-1:0]        coeff_in,
    output logic                                     tap_done,
    output logic signed [tsfm_pkg::OUT_W-1:0]        filt
);
    import tsfm_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

    logic [COEFF_W-1:0]      coeff_sr_reg, coeff_sr_next;
    logic [DIGIT_CNT_W-1:0]  digit_reg, digit_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic                    last_digit;
    logic signed [DIGIT_W:0] dig_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] shifted;

    assign last_digit = (digit_reg == DIGIT_CNT_W'(DIGITS - 1));
    assign tap_done   = ctrl.step && last_digit;

    // top digit carries the coefficient sign
    always_comb begin
        if (last_digit) begin
            dig_s = $signed({coeff_sr_reg[DIGIT_W-1], coeff_sr_reg[DIGIT_W-1:0]});
        end else begin
            dig_s = $signed({1'b0, coeff_sr_reg[DIGIT_W-1:0]});
        end
        prod     = sample * dig_s;
        prod_ext = ACC_W'(prod);
        shifted  = prod_ext <<< (DIGIT_W * digit_reg);
    end

    always_comb begin
        coeff_sr_next = coeff_sr_reg;
        digit_next    = digit_reg;
        acc_next      = acc_reg;
        if (ctrl.start) begin
            coeff_sr_next = coeff_in;
            digit_next    = '0;
            acc_next      = '0;
        end else if (ctrl.step) begin
            acc_next = acc_reg + shifted;
            if (last_digit) begin
                coeff_sr_next = coeff_in;
                digit_next    = '0;
            end else begin
                coeff_sr_next = coeff_sr_reg >> DIGIT_W;
                digit_next    = digit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_reg <= '0;
        end else begin
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        coeff_sr_reg <= coeff_sr_next;
        acc_reg      <= acc_next;
    end

    logic signed [ACC_W-1:0] acc_q;

    always_comb begin
        acc_q = acc_reg >>> FRAC_W;
        if (acc_q > SAT_HI) begin
            filt = OUT_W'(SAT_HI);
        end else if (acc_q < SAT_LO) begin
            filt = OUT_W'(SAT_LO);
        end else begin
            filt = OUT_W'(acc_q);
        end
    end

endmodule

`default_nettype wire

@@ rtl/temp_sensor_fir_monitor_core.sv @@
// Top level: temperature conversion, sample window, sequencer, alarm, display strobe.
//
// Input channel s_valid/s_ready carries one 12-bit ADC sample per item. Each
// item yields exactly one result item on m_valid/m_ready: the sample's
// temperature (Q8 degrees), the alarm flag, the display strobe and the
// filtered temperature (zero when the strobe is low).
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
// is always high, and writes belong in idle time. Indexes above 6 are ignored.
// An item is accepted in idle; then the FIR multiplier consumes one 4-bit
// coefficient digit per cycle, four digits per tap, and a finishing step
// registers the result and raises m_valid.
// A result waits in the output register while the receiver stalls; the next
// item is accepted meanwhile, and its finishing step holds until the output
// register is free.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// sample window, display count and alarm flag, and empties the output.
`default_nettype none

module temp_sensor_fir_monitor_core #(
    parameter int TAPS = 5
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [tsfm_pkg::RAW_W-1:0]           s_raw_sample,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [tsfm_pkg::TEMP_W-1:0]        m_current_temp,
    output logic                                      m_over_threshold,
    output logic                                      m_display_valid,
    output logic signed [tsfm_pkg::OUT_W-1:0]         m_display_temp,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tsfm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tsfm_pkg::COEFF_W-1:0]         cfg_data
);
    import tsfm_pkg::*;

    localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    cfg_t      cfg;
    mac_ctrl_t mac_ctrl;
    logic      tap_done;
    logic signed [OUT_W-1:0] filt;

    state_t state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic signed [TEMP_W-1:0] hist_reg [HIST_D];
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic alarm_reg, alarm_next;

    logic m_valid_reg, m_valid_next;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic out_alarm_reg;
    logic out_strobe_reg;
    logic signed [OUT_W-1:0] out_filt_reg;

    logic accept;
    logic finish;
    logic out_free;
    logic [TEMP_W-1:0] scaled;
    logic [HIST_IDX_W-1:0] hidx;
    logic [COEFF_IDX_W-1:0] cidx;
    logic signed [TEMP_W-1:0] sample;
    logic signed [TEMP_W-1:0] thr;
    logic strobe;

    tsfm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsfm_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .sample   (sample),
        .coeff_in (cfg.coeff[cidx]),
        .tap_done (tap_done),
        .filt     (filt)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_MAC;
            ST_MAC:  if (tap_done && tap_reg == LAST_TAP) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready        = 1'b0;
        mac_ctrl.start = 1'b0;
        mac_ctrl.step  = 1'b0;
        finish         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                mac_ctrl.start = s_valid;
            end
            ST_MAC:  mac_ctrl.step = 1'b1;
            ST_DONE: finish = out_free;
            default: s_ready = 1'b0;
        endcase
    end

    assign scaled    = TEMP_W'(s_raw_sample) * TEMP_W'(TEMP_GAIN);
    assign temp_next = accept ? $signed(scaled - TEMP_W'(TEMP_OFFSET)) : temp_reg;

    // window[TAPS-1] is the current sample, lower taps walk back in history
    assign hidx   = HIST_IDX_W'(TAPS - 2 - int'(tap_reg));
    assign sample = (tap_reg == LAST_TAP) ? temp_next : hist_reg[hidx];

    always_comb begin
        if (mac_ctrl.start || tap_reg == LAST_TAP) begin
            cidx = '0;
        end else begin
            cidx = COEFF_IDX_W'(int'(tap_reg) + 1);
        end
    end

    always_comb begin
        tap_next = tap_reg;
        if (mac_ctrl.start) begin
            tap_next = '0;
        end else if (tap_done) begin
            tap_next = (tap_reg == LAST_TAP) ? '0 : tap_reg + 1'b1;
        end
    end

    assign thr    = $signed({cfg.threshold, THR_SHIFT'(0)});
    assign strobe = (count_reg >= cfg.period);

    always_comb begin
        alarm_next = alarm_reg;
        count_next = count_reg;
        if (finish) begin
            if (temp_reg > thr) begin
                alarm_next = 1'b1;
            end else if (temp_reg < thr) begin
                alarm_next = 1'b0;
            end
            count_next = strobe ? '0 : count_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            count_reg   <= '0;
            alarm_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < HIST_D; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            count_reg   <= count_next;
            alarm_reg   <= alarm_next;
            m_valid_reg <= m_valid_next;
            if (finish) begin
                for (int i = HIST_D - 1; i > 0; i--) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= temp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        temp_reg <= temp_next;
        if (finish) begin
            out_temp_reg   <= temp_reg;
            out_alarm_reg  <= alarm_next;
            out_strobe_reg <= strobe;
            out_filt_reg   <= strobe ? filt : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_current_temp   = out_temp_reg;
    assign m_over_threshold = out_alarm_reg;
    assign m_display_valid  = out_strobe_reg;
    assign m_display_temp   = out_filt_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_MAC)
        else $error("accepted item did not start the MAC sequence");

    a_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MAC |-> tap_reg <= LAST_TAP)
        else $error("tap index beyond window");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the finishing step");

    a_no_strobe_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_display_valid |-> m_display_temp == '0)
        else $error("display value nonzero without strobe");
`endif

endmodule

`default_nettype wire
